### design/unsigned_128bit_divider_defines.svh
// Assertion macros for the unsigned divider checker.
// Included by udiv_checker.sv; depends on nothing else.
`ifndef UNSIGNED_128BIT_DIVIDER_DEFINES_SVH
`define UNSIGNED_128BIT_DIVIDER_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define UDIV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define UDIV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/udiv_pkg.sv
// Shared types for the unsigned divider pipeline.
// Used by udiv_cell.sv and unsigned_128bit_divider.sv; no dependencies.
`default_nettype none

package udiv_pkg;

  // Control that travels alongside each request through the cell chain.
  typedef struct packed {
    logic valid;
    logic dz;
  } ctrl_t;

endpackage

`default_nettype wire

### design/udiv_cell.sv
// One restoring-division step with its own pipeline register.
// Depends on udiv_pkg for the control struct.
`default_nettype none

module udiv_cell #(
  parameter int unsigned Width = 128
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire udiv_pkg::ctrl_t      in_ctrl_i,
  input  wire logic [Width-1:0]     in_rem_i,
  input  wire logic [Width-1:0]     in_nq_i,
  input  wire logic [Width-1:0]     in_dvs_i,
  output logic                      in_ready_o,
  output udiv_pkg::ctrl_t           out_ctrl_o,
  output logic [Width-1:0]          out_rem_o,
  output logic [Width-1:0]          out_nq_o,
  output logic [Width-1:0]          out_dvs_o,
  input  wire logic                 out_ready_i
);

  udiv_pkg::ctrl_t    ctrl_q;
  logic [Width-1:0]   rem_q, rem_d;
  logic [Width-1:0]   nq_q, nq_d;
  logic [Width-1:0]   dvs_q;
  logic [Width:0]     trial;
  logic [Width:0]     diff;
  logic               ge;

  // The stage takes a new request when it is empty or its content moves on.
  assign in_ready_o = !ctrl_q.valid || out_ready_i;

  // Shift the next dividend bit into the partial remainder and try the subtract.
  // The remainder stays below the divisor, so a set top bit of the
  // difference means the trial value was smaller than the divisor.
  always_comb begin
    trial = {in_rem_i, in_nq_i[Width-1]};
    diff  = trial - {1'b0, in_dvs_i};
    ge    = !diff[Width];
    rem_d = ge ? diff[Width-1:0] : trial[Width-1:0];
    nq_d  = {in_nq_i[Width-2:0], ge};
  end

  // Control register; reset empties the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (in_ready_o) begin
      ctrl_q <= in_ctrl_i;
    end
  end

  // Payload registers load only with a valid request.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_ctrl_i.valid) begin
      rem_q <= rem_d;
      nq_q  <= nq_d;
      dvs_q <= in_dvs_i;
    end
  end

  assign out_ctrl_o = ctrl_q;
  assign out_rem_o  = rem_q;
  assign out_nq_o   = nq_q;
  assign out_dvs_o  = dvs_q;

endmodule

`default_nettype wire

### design/unsigned_128bit_divider.sv
// Top level of the pipelined unsigned divider: a chain of udiv_cell stages.
// Depends on udiv_pkg and udiv_cell.
//
//   Channel   Handshake              Payload
//   in        in_valid_i/in_ready_o  dividend_hi/lo_i, divisor_hi/lo_i
//   out       out_valid_o/out_ready_i quotient_hi/lo_o, remainder_hi/lo_o,
//                                    div_by_zero_o
//
// One request enters per cycle unless a stalled output has backed up the chain;
// the chain holds one cell per quotient bit.
// Reset clears only the per-cell control bits (valid and dz); the chain comes up empty.
// A stalled output holds its result; cells behind it keep filling, so empty
// cells are squeezed out and requests are still taken while results wait.
// A zero divisor gives an all-ones quotient, the dividend as remainder and
// raises div_by_zero_o.
`default_nettype none

module unsigned_128bit_divider #(
  parameter int unsigned HALF_WIDTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [HALF_WIDTH-1:0] dividend_hi_i,
  input  wire logic [HALF_WIDTH-1:0] dividend_lo_i,
  input  wire logic [HALF_WIDTH-1:0] divisor_hi_i,
  input  wire logic [HALF_WIDTH-1:0] divisor_lo_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [HALF_WIDTH-1:0]      quotient_hi_o,
  output logic [HALF_WIDTH-1:0]      quotient_lo_o,
  output logic [HALF_WIDTH-1:0]      remainder_hi_o,
  output logic [HALF_WIDTH-1:0]      remainder_lo_o,
  output logic                       div_by_zero_o
);

  localparam int unsigned Width = 2 * HALF_WIDTH;

  udiv_pkg::ctrl_t    link_ctrl  [Width+1];
  logic [Width-1:0]   link_rem   [Width+1];
  logic [Width-1:0]   link_nq    [Width+1];
  logic [Width-1:0]   link_dvs   [Width+1];
  logic               link_ready [Width+1];

  // Entry: empty partial remainder, dividend in the shift register.
  assign link_ctrl[0] = udiv_pkg::ctrl_t'({in_valid_i, ~|{divisor_hi_i, divisor_lo_i}});
  assign link_rem[0]  = '0;
  assign link_nq[0]   = {dividend_hi_i, dividend_lo_i};
  assign link_dvs[0]  = {divisor_hi_i, divisor_lo_i};

  assign in_ready_o = link_ready[0];

  // One cell per quotient bit, most significant first.
  for (genvar g = 0; g < Width; g++) begin : g_cell
    udiv_cell #(
      .Width(Width)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_ctrl_i  (link_ctrl[g]),
      .in_rem_i   (link_rem[g]),
      .in_nq_i    (link_nq[g]),
      .in_dvs_i   (link_dvs[g]),
      .in_ready_o (link_ready[g]),
      .out_ctrl_o (link_ctrl[g+1]),
      .out_rem_o  (link_rem[g+1]),
      .out_nq_o   (link_nq[g+1]),
      .out_dvs_o  (link_dvs[g+1]),
      .out_ready_i(link_ready[g+1])
    );
  end

  // The last cell's register is the output register.
  assign link_ready[Width] = out_ready_i;
  assign out_valid_o       = link_ctrl[Width].valid;
  assign div_by_zero_o     = link_ctrl[Width].dz;
  assign quotient_hi_o     = link_nq[Width][Width-1:HALF_WIDTH];
  assign quotient_lo_o     = link_nq[Width][HALF_WIDTH-1:0];
  assign remainder_hi_o    = link_rem[Width][Width-1:HALF_WIDTH];
  assign remainder_lo_o    = link_rem[Width][HALF_WIDTH-1:0];

endmodule

`default_nettype wire

### design/udiv_checker.sv
// Port-level checks for the unsigned divider, bound to the top level.
// Depends on unsigned_128bit_divider_defines.svh and unsigned_128bit_divider.
`default_nettype none
`include "unsigned_128bit_divider_defines.svh"

module udiv_checker #(
  parameter int unsigned HALF_WIDTH = 64
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic [HALF_WIDTH-1:0] dividend_hi_i,
  input wire logic [HALF_WIDTH-1:0] dividend_lo_i,
  input wire logic [HALF_WIDTH-1:0] divisor_hi_i,
  input wire logic [HALF_WIDTH-1:0] divisor_lo_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [HALF_WIDTH-1:0] quotient_hi_o,
  input wire logic [HALF_WIDTH-1:0] quotient_lo_o,
  input wire logic [HALF_WIDTH-1:0] remainder_hi_o,
  input wire logic [HALF_WIDTH-1:0] remainder_lo_o,
  input wire logic                  div_by_zero_o
);

  // A stalled result stays valid; its low quotient and remainder halves and div_by_zero_o stay unchanged.
  `UDIV_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(quotient_lo_o) && $stable(remainder_lo_o) && $stable(div_by_zero_o), "Stalled result changed")

  // A divide by zero always reports an all-ones quotient.
  `UDIV_ASSERT(a_dz_quot, clk_i, rst_ni, out_valid_o && div_by_zero_o |-> (&quotient_hi_o) && (&quotient_lo_o), "Divide by zero without all-ones quotient")

  // With the output empty the whole chain can move, so a request is taken.
  `UDIV_ASSERT(a_ready_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "Input stalled with empty output")

  // Reset leaves no result behind.
  `UDIV_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o, "Result valid after reset")

endmodule

bind unsigned_128bit_divider udiv_checker #(.HALF_WIDTH(HALF_WIDTH)) u_udiv_checker (.*);

`default_nettype wire
